[rtl/dual_pedal_position_calibrator_core_macros.svh]
// Assertion helpers for the pedal calibrator. Each expands to a concurrent
// assertion clocked on i_clk and held off while i_rst_n is low.
`ifndef DUAL_PEDAL_POSITION_CALIBRATOR_CORE_MACROS_SVH
`define DUAL_PEDAL_POSITION_CALIBRATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define DPPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dppc assertion failed");
`define DPPC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dppc assertion failed");
`else
`define DPPC_ASSERT_IMP(lbl, ante, cons)
`define DPPC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/dppc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dppc_pkg;

    // Actions selected by the func field of an input beat. The three top codes
    // are spare and leave the calibration bounds untouched.
    typedef enum logic [2:0] {
        FN_BEGIN  = 3'd0,
        FN_MAX    = 3'd1,
        FN_MIN    = 3'd2,
        FN_END    = 3'd3,
        FN_POS    = 3'd4,
        FN_RSVD5  = 3'd5,
        FN_RSVD6  = 3'd6,
        FN_RSVD7  = 3'd7
    } t_func;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

[rtl/dual_pedal_position_calibrator_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  tdata, lowest bit first     tuser, lowest bit first
// s_axis   in   sample_a, sample_b          func[2:0], conversion_ok
// m_axis   out  position, zero fill         is_position, span_fault, failsafe_applied
//
// Calibration actions, spare codes and span-fault positions: the result beat is loaded at the
// edge that accepts the input beat. A position sample is computed by the bit-serial divider,
// which runs at most once per sensor, in turn; a reading outside its span is clamped without
// division. Reset (synchronous, active low) restores the uncalibrated bounds and empties the
// output register. A stalled output beat holds the block: no input beat is taken while the
// output beat waits.

`include "dual_pedal_position_calibrator_core_macros.svh"

module dual_pedal_position_calibrator_core
    import dppc_pkg::*;
#(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,

    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // sample_a, sample_b, zero fill
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // func[2:0], conversion_ok
    input  wire logic [3:0]                s_axis_tuser,

    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // position, zero fill
    output logic [((FRACTION_BITS+8)/8)*8-1:0] m_axis_tdata,
    // is_position, span_fault, failsafe_applied
    output logic [2:0]                     m_axis_tuser
);

    localparam int OUT_TDATA_W = ((FRACTION_BITS + 8) / 8) * 8;
    localparam logic [SAMPLE_BITS:0]   LOWER_RESET = {1'b1, {SAMPLE_BITS{1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE  = {SAMPLE_BITS{1'b1}};
    localparam logic [FRACTION_BITS:0] ONE         = {1'b1, {FRACTION_BITS{1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SENS = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Input beat fields.
    t_func                  in_func;
    logic                   in_ok;
    logic [SAMPLE_BITS-1:0] in_sample_a;
    logic [SAMPLE_BITS-1:0] in_sample_b;
    logic                   in_accept;

    assign in_func     = t_func'(s_axis_tuser[2:0]);
    assign in_ok       = s_axis_tuser[3];
    assign in_sample_a = s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_sample_b = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // Calibration bounds. A lower bound is one bit wider so that it can hold
    // the uncalibrated value just above full scale.
    logic [SAMPLE_BITS-1:0] r_upper_a, n_upper_a;
    logic [SAMPLE_BITS:0]   r_lower_a, n_lower_a;
    logic [SAMPLE_BITS-1:0] r_upper_b, n_upper_b;
    logic [SAMPLE_BITS:0]   r_lower_b, n_lower_b;

    t_state                   r_state;
    logic                     r_sel;
    logic [SAMPLE_BITS-1:0]   r_raw_a;
    logic [SAMPLE_BITS-1:0]   r_raw_b;
    logic [FRACTION_BITS+1:0] r_sum;

    // Output register.
    logic                     r_m_valid;
    logic [FRACTION_BITS:0]   r_m_pos;
    logic                     r_m_is_pos;
    logic                     r_m_fault;
    logic                     r_m_fs;

    logic out_free;
    logic bad_a;
    logic bad_b;
    logic bad_any;

    assign out_free      = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // A span is unusable when the upper bound does not exceed the lower one.
    assign bad_a   = {1'b0, r_upper_a} <= r_lower_a;
    assign bad_b   = {1'b0, r_upper_b} <= r_lower_b;
    assign bad_any = bad_a || bad_b;

    always_comb begin
        n_upper_a = r_upper_a;
        n_lower_a = r_lower_a;
        n_upper_b = r_upper_b;
        n_lower_b = r_lower_b;
        if (in_accept) begin
            case (in_func)
                FN_BEGIN: begin
                    n_upper_a = '0;
                    n_upper_b = '0;
                    n_lower_a = LOWER_RESET;
                    n_lower_b = LOWER_RESET;
                end
                FN_MAX: begin
                    if (in_ok) begin
                        if (in_sample_a > r_upper_a) n_upper_a = in_sample_a;
                        if (in_sample_b > r_upper_b) n_upper_b = in_sample_b;
                    end
                end
                FN_MIN: begin
                    if (in_ok) begin
                        if ({1'b0, in_sample_a} < r_lower_a) n_lower_a = {1'b0, in_sample_a};
                        if ({1'b0, in_sample_b} < r_lower_b) n_lower_b = {1'b0, in_sample_b};
                    end
                end
                FN_END: begin
                    // Failsafe: fall back to the whole converter range.
                    if (bad_any) begin
                        n_upper_a = FULL_SCALE;
                        n_upper_b = FULL_SCALE;
                        n_lower_a = '0;
                        n_lower_b = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Per-sensor step of a position sample. The sensor in hand is chosen by
    // r_sel; bounds cannot change while a position sample is in flight.
    logic [SAMPLE_BITS-1:0]   cur_raw;
    logic [SAMPLE_BITS-1:0]   cur_up;
    logic [SAMPLE_BITS:0]     cur_lo;
    logic                     cur_below;
    logic                     cur_above;
    logic [SAMPLE_BITS-1:0]   cur_diff;
    logic [SAMPLE_BITS-1:0]   cur_span;
    logic                     div_start;
    t_div_stat                div_stat;
    logic [FRACTION_BITS-1:0] div_quo;
    logic                     step_done;
    logic [FRACTION_BITS:0]   q_add;

    assign cur_raw   = r_sel ? r_raw_b : r_raw_a;
    assign cur_up    = r_sel ? r_upper_b : r_upper_a;
    assign cur_lo    = r_sel ? r_lower_b : r_lower_a;
    assign cur_below = {1'b0, cur_raw} <= cur_lo;
    assign cur_above = cur_raw >= cur_up;
    // With a valid span the lower bound lies below full scale, so its top
    // bit is clear and the narrow differences are exact.
    assign cur_diff  = cur_raw - cur_lo[SAMPLE_BITS-1:0];
    assign cur_span  = cur_up - cur_lo[SAMPLE_BITS-1:0];

    assign div_start = (r_state == S_SENS) && !cur_below && !cur_above;

    always_comb begin
        step_done = 1'b0;
        q_add     = '0;
        case (r_state)
            S_SENS: begin
                if (cur_below || cur_above) begin
                    step_done = 1'b1;
                    q_add     = cur_below ? '0 : ONE;
                end
            end
            S_WAIT: begin
                if (div_stat.done) begin
                    step_done = 1'b1;
                    q_add     = {1'b0, div_quo};
                end
            end
            default: begin
            end
        endcase
    end

    dppc_div #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (cur_diff),
        .i_divisor  (cur_span),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    // Sequencer and calibration state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sel     <= 1'b0;
            r_upper_a <= '0;
            r_upper_b <= '0;
            r_lower_a <= LOWER_RESET;
            r_lower_b <= LOWER_RESET;
        end else begin
            r_upper_a <= n_upper_a;
            r_upper_b <= n_upper_b;
            r_lower_a <= n_lower_a;
            r_lower_b <= n_lower_b;
            case (r_state)
                S_IDLE: begin
                    if (in_accept && (in_func == FN_POS) && !bad_any) begin
                        r_state <= S_SENS;
                        r_sel   <= 1'b0;
                    end
                end
                S_SENS: begin
                    if (step_done) begin
                        r_sel   <= 1'b1;
                        r_state <= r_sel ? S_DONE : S_SENS;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (step_done) begin
                        r_sel   <= 1'b1;
                        r_state <= r_sel ? S_DONE : S_SENS;
                    end
                end
                S_DONE: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Readings and the running sum of both fractions. A failed conversion
    // reads as zero on both sensors.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_raw_a <= in_ok ? in_sample_a : '0;
            r_raw_b <= in_ok ? in_sample_b : '0;
            r_sum   <= '0;
        end else if (step_done) begin
            r_sum <= r_sum + {1'b0, q_add};
        end
    end

    // Output register: loaded either straight from an accepted beat or when
    // the position sequence finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (in_accept && !((in_func == FN_POS) && !bad_any)) begin
            r_m_valid <= 1'b1;
        end else if ((r_state == S_DONE) && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_m_pos    <= '0;
            r_m_is_pos <= in_func == FN_POS;
            r_m_fault  <= (in_func == FN_POS) && bad_any;
            r_m_fs     <= (in_func == FN_END) && bad_any;
        end else if ((r_state == S_DONE) && out_free) begin
            // Truncating average of the two fractions.
            r_m_pos    <= r_sum[FRACTION_BITS+1:1];
            r_m_is_pos <= 1'b1;
            r_m_fault  <= 1'b0;
            r_m_fs     <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_m_pos);
    assign m_axis_tuser  = {r_m_fs, r_m_fault, r_m_is_pos};

    `DPPC_ASSERT_IMP(a_fault_zero, r_m_valid && r_m_fault, r_m_pos == '0)
    `DPPC_ASSERT_IMP(a_pos_range, r_m_valid, r_m_pos <= ONE)
    `DPPC_ASSERT_IMP(a_no_accept_busy, div_stat.busy, !s_axis_tready)
    `DPPC_ASSERT_IMP(a_done_in_wait, div_stat.done, r_state == S_WAIT)
    `DPPC_ASSERT_NXT(a_pos_starts, in_accept && (in_func == FN_POS) && !bad_any, r_state == S_SENS)

endmodule

`default_nettype wire

[rtl/dppc_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. Computes
// floor(dividend * 2^FRACTION_BITS / divisor) for dividend < divisor.
module dppc_div
    import dppc_pkg::*;
#(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [SAMPLE_BITS-1:0]   i_dividend,
    input  wire logic [SAMPLE_BITS-1:0]   i_divisor,
    output t_div_stat                     o_stat,
    output logic      [FRACTION_BITS-1:0] o_quotient
);

    localparam int CNT_W = $clog2(FRACTION_BITS + 1);

    logic [SAMPLE_BITS-1:0]   r_rem;
    logic [SAMPLE_BITS-1:0]   r_div;
    logic [FRACTION_BITS-1:0] r_quo;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_busy;
    logic                     r_done;

    logic [SAMPLE_BITS:0]     w_shift;
    logic                     w_ge;
    logic [SAMPLE_BITS:0]     w_sub;

    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_sub   = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRACTION_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[SAMPLE_BITS-1:0] : w_shift[SAMPLE_BITS-1:0];
            r_quo <= {r_quo[FRACTION_BITS-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench
    import dppc_pkg::*;
();

    localparam int FRAC_W      = 16;
    localparam int SAMPLE_MAX  = 4095;
    localparam int LOWER_CLEAR = 4096;
    localparam int STALL_LEN   = 300;
    localparam int ITEM_GOAL   = 1750;
    localparam int DRAIN_LEN   = 60;

    typedef struct packed {
        logic [16:0] position;
        logic        is_position;
        logic        span_fault;
        logic        failsafe;
    } t_pedal_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // sample_a, sample_b
    logic [3:0]  s_axis_tuser = '0;   // func[2:0], conversion_ok
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // position, zero fill
    logic [2:0]  m_axis_tuser;        // is_position, span_fault, failsafe_applied

    // Calibration bounds as the block should hold them.
    logic [11:0] cal_upper_a;
    logic [12:0] cal_lower_a;
    logic [11:0] cal_upper_b;
    logic [12:0] cal_lower_b;

    t_pedal_result pending_results[$];
    int  mismatches    = 0;
    int  beats_counted = 0;
    bit  calm          = 1'b0;
    int  stall_requests = 0;
    int  stall_served   = 0;
    int  stall_left     = 0;

    dual_pedal_position_calibrator_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Fraction of the span covered by one reading, in Q1.16.
    function automatic logic [17:0] sensor_fraction(logic [11:0] raw, logic [11:0] upper,
                                                    logic [12:0] lower);
        logic [31:0] num;
        logic [31:0] span;
        if ({1'b0, raw} <= lower) return '0;
        if (raw >= upper) return 18'(1 << FRAC_W);
        num  = ({20'd0, raw} - {19'd0, lower}) << FRAC_W;
        span = {20'd0, upper} - {19'd0, lower};
        return 18'(num / span);
    endfunction

    function automatic t_pedal_result predict_pedal(t_func func, logic [11:0] a,
                                                    logic [11:0] b, logic ok);
        t_pedal_result r;
        logic [17:0]   qa;
        logic [17:0]   qb;
        logic          bad;
        r   = '0;
        bad = ({1'b0, cal_upper_a} <= cal_lower_a) || ({1'b0, cal_upper_b} <= cal_lower_b);
        case (func)
            FN_BEGIN: begin
                cal_upper_a = '0;
                cal_lower_a = 13'(LOWER_CLEAR);
                cal_upper_b = '0;
                cal_lower_b = 13'(LOWER_CLEAR);
            end
            FN_MAX: begin
                if (ok) begin
                    if (a > cal_upper_a) cal_upper_a = a;
                    if (b > cal_upper_b) cal_upper_b = b;
                end
            end
            FN_MIN: begin
                if (ok) begin
                    if ({1'b0, a} < cal_lower_a) cal_lower_a = {1'b0, a};
                    if ({1'b0, b} < cal_lower_b) cal_lower_b = {1'b0, b};
                end
            end
            FN_END: begin
                if (bad) begin
                    cal_lower_a = '0;
                    cal_upper_a = 12'(SAMPLE_MAX);
                    cal_lower_b = '0;
                    cal_upper_b = 12'(SAMPLE_MAX);
                    r.failsafe  = 1'b1;
                end
            end
            FN_POS: begin
                r.is_position = 1'b1;
                // A failed conversion reads as zero on both sensors.
                if (!ok) begin
                    a = '0;
                    b = '0;
                end
                if (bad) begin
                    r.span_fault = 1'b1;
                end else begin
                    qa = sensor_fraction(a, cal_upper_a, cal_lower_a);
                    qb = sensor_fraction(b, cal_upper_b, cal_lower_b);
                    r.position = 17'((qa + qb) >> 1);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // A reading a few counts either side of a bound, kept inside the sample range.
    function automatic logic [11:0] near_bound(int base);
        int v;
        v = base + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        return 12'(v);
    endfunction

    // Mostly within the given window, now and then anywhere in the range.
    function automatic logic [11:0] sample_in(int lo, int hi);
        if ($urandom_range(4) == 0) return 12'($urandom_range(SAMPLE_MAX));
        return 12'($urandom_range(hi, lo));
    endfunction

    // Offers one input beat, waits for it to be taken and records its result.
    task automatic send_pedal_beat(t_func func, logic [11:0] a, logic [11:0] b,
                                   logic ok);
        if (!calm) begin
            while ($urandom_range(99) < 34) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= {ok, func};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(predict_pedal(func, a, b, ok));
        if (func <= FN_POS) beats_counted++;
    endtask

    // One calibration followed by position samples. Now and then the begin or
    // end action is dropped, and stray actions are mixed in as noise.
    task automatic calibration_round();
        int   n;
        int   i;
        int   mode;
        logic broken;
        logic [11:0] a;
        logic [11:0] b;
        broken = ($urandom_range(99) < 15);
        if (!(broken && $urandom_range(1)))
            send_pedal_beat(FN_BEGIN, 12'($urandom), 12'($urandom), 1'($urandom));
        n = $urandom_range(4, 1);
        for (i = 0; i < n; i++)
            send_pedal_beat(FN_MAX, sample_in(2048, SAMPLE_MAX),
                            sample_in(2048, SAMPLE_MAX), $urandom_range(9) != 0);
        if ($urandom_range(9) == 0)
            send_pedal_beat(t_func'($urandom_range(7)), 12'($urandom),
                            12'($urandom), 1'($urandom));
        n = $urandom_range(4, 1);
        for (i = 0; i < n; i++)
            send_pedal_beat(FN_MIN, sample_in(0, 2047), sample_in(0, 2047),
                            $urandom_range(9) != 0);
        if (!(broken && $urandom_range(1)))
            send_pedal_beat(FN_END, 12'($urandom), 12'($urandom), 1'($urandom));
        n = $urandom_range(12, 2);
        for (i = 0; i < n; i++) begin
            mode = $urandom_range(2);
            case (mode)
                0: begin
                    a = 12'($urandom);
                    b = 12'($urandom);
                end
                1: begin
                    a = near_bound(int'(cal_lower_a));
                    b = near_bound(int'(cal_lower_b));
                end
                default: begin
                    a = near_bound(int'(cal_upper_a));
                    b = near_bound(int'(cal_upper_b));
                end
            endcase
            send_pedal_beat(FN_POS, a, b, $urandom_range(9) != 0);
        end
        if ($urandom_range(9) == 0)
            send_pedal_beat(t_func'($urandom_range(7)), 12'($urandom),
                            12'($urandom), 1'($urandom));
    endtask

    // Extremes of every field, every action and the named corner cases.
    task automatic test_directed_cases();
        // Straight out of reset both spans are empty.
        send_pedal_beat(FN_POS,   12'hFFF, 12'h000, 1'b1);
        send_pedal_beat(FN_END,   12'h000, 12'h000, 1'b1);
        send_pedal_beat(FN_POS,   12'h000, 12'h000, 1'b1);
        send_pedal_beat(FN_POS,   12'hFFF, 12'hFFF, 1'b1);
        send_pedal_beat(FN_POS,   12'h800, 12'h001, 1'b1);
        send_pedal_beat(FN_POS,   12'hFFF, 12'hFFF, 1'b0);
        // Reserved codes must leave the bounds alone.
        send_pedal_beat(FN_RSVD5, 12'hFFF, 12'h000, 1'b1);
        send_pedal_beat(FN_RSVD6, 12'h000, 12'hFFF, 1'b0);
        send_pedal_beat(FN_RSVD7, 12'hFFF, 12'hFFF, 1'b1);
        send_pedal_beat(FN_BEGIN, 12'hFFF, 12'hFFF, 1'b1);
        send_pedal_beat(FN_MAX,   12'hFFF, 12'hFFF, 1'b0);
        send_pedal_beat(FN_MAX,   12'd3000, 12'hFFF, 1'b1);
        send_pedal_beat(FN_MIN,   12'h000, 12'hFFE, 1'b1);
        send_pedal_beat(FN_MIN,   12'h000, 12'h000, 1'b0);
        // Sensor b now has a span of a single count.
        send_pedal_beat(FN_END,   12'h000, 12'h000, 1'b0);
        send_pedal_beat(FN_POS,   12'd1500, 12'hFFE, 1'b1);
        send_pedal_beat(FN_POS,   12'd3001, 12'hFFF, 1'b1);
        send_pedal_beat(FN_POS,   12'hAAA, 12'h555, 1'b1);
        // Equal bounds on sensor a, and no end action before sampling.
        send_pedal_beat(FN_BEGIN, 12'h000, 12'h000, 1'b0);
        send_pedal_beat(FN_MAX,   12'd100, 12'd200, 1'b1);
        send_pedal_beat(FN_MIN,   12'd100, 12'd50, 1'b1);
        send_pedal_beat(FN_POS,   12'd150, 12'd40, 1'b1);
        send_pedal_beat(FN_END,   12'hFFF, 12'hFFF, 1'b1);
        send_pedal_beat(FN_POS,   12'h555, 12'hAAA, 1'b1);
    endtask

    // Back-to-back beats on both sides.
    task automatic test_calm_calibration();
        int i;
        calm = 1'b1;
        for (i = 0; i < 4; i++) calibration_round();
        calm = 1'b0;
    endtask

    // The sink holds off for a long stretch while position samples keep coming,
    // so the output register fills and the input is stalled.
    task automatic test_output_stall();
        int i;
        stall_requests++;
        calm = 1'b1;
        for (i = 0; i < 24; i++)
            send_pedal_beat(FN_POS, 12'($urandom), 12'($urandom), 1'b1);
        calm = 1'b0;
    endtask

    task automatic test_random_sequences();
        while (beats_counted < ITEM_GOAL) calibration_round();
    endtask

    task automatic note_mismatch(string what, t_pedal_result want, t_pedal_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%t mismatch (%s): expected pos=%0d is_pos=%0b fault=%0b fs=%0b",
                     $realtime, what, want.position, want.is_position, want.span_fault,
                     want.failsafe);
            $display("    got pos=%0d is_pos=%0b fault=%0b fs=%0b",
                     got.position, got.is_position, got.span_fault, got.failsafe);
        end
    endtask

    // Sink side: random back-pressure, a quiet spell, and one long hold-off.
    always @(posedge i_clk) begin
        if (stall_requests != stall_served) begin
            stall_served++;
            stall_left = STALL_LEN;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= 34);
        end
    end

    // Every result beat is compared with the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_pedal_result got;
        t_pedal_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.position    = m_axis_tdata[16:0];
            got.is_position = m_axis_tuser[0];
            got.span_fault  = m_axis_tuser[1];
            got.failsafe    = m_axis_tuser[2];
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected beat", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) note_mismatch("field", want, got);
            end
        end
    end

    initial begin
        cal_upper_a = '0;
        cal_lower_a = 13'(LOWER_CLEAR);
        cal_upper_b = '0;
        cal_lower_b = 13'(LOWER_CLEAR);
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_calm_calibration();
        test_output_stall();
        test_random_sequences();
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_LEN) @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/dppc_pkg.sv
rtl/dppc_div.sv
rtl/dual_pedal_position_calibrator_core.sv
sim/testbench.sv
